FILE: hdl/qrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_pkg
// Shared constants and types for the quadratic real-roots core.
// ----------------------------------------------------------------------------
package qrr_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DISC_OUT_W     = 34;
    localparam int ROOT_OUT_W     = 40;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2
    } root_count_t;

    typedef struct packed {
        root_count_t count;
        logic        lead;
    } root_flags_t;

    localparam int FLAGS_W = $bits(root_flags_t);

endpackage

FILE: hdl/qrr_coef_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_coef_if
// Coefficient channel: valid/ready with one coefficient triple.
// ----------------------------------------------------------------------------
interface qrr_coef_if #(
    parameter int COEF_WIDTH = qrr_pkg::COEF_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_square;
    logic signed [COEF_WIDTH-1:0] coef_linear;
    logic signed [COEF_WIDTH-1:0] coef_const;

    modport source (output valid, coef_square, coef_linear, coef_const, input ready);
    modport sink   (input valid, coef_square, coef_linear, coef_const, output ready);
endinterface

FILE: hdl/qrr_root_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_root_if
// Result channel: valid/ready with root count, discriminant and roots.
// ----------------------------------------------------------------------------
interface qrr_root_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            root_count;
    logic signed [qrr_pkg::DISC_OUT_W-1:0] disc_value;
    logic signed [qrr_pkg::ROOT_OUT_W-1:0] root_plus;
    logic signed [qrr_pkg::ROOT_OUT_W-1:0] root_minus;
    logic                                  lead_zero;

    modport source (output valid, root_count, disc_value, root_plus, root_minus, lead_zero,
                    input ready);
    modport sink   (input valid, root_count, disc_value, root_plus, root_minus, lead_zero,
                    output ready);
endinterface

FILE: hdl/qrr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_front
// Accepts coefficient triples, forms the exact discriminant and classifies it.
// ----------------------------------------------------------------------------
module qrr_front #(
    parameter int COEF_WIDTH = qrr_pkg::COEF_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    qrr_coef_if.sink                     coef,
    input  logic                         queue_full,
    output logic                         push,
    output logic signed [COEF_WIDTH-1:0] push_a,
    output logic signed [COEF_WIDTH-1:0] push_b,
    output logic signed [2*COEF_WIDTH+1:0] push_disc,
    output qrr_pkg::root_flags_t         push_flags
);
    localparam int CW = COEF_WIDTH;
    localparam int DW = 2 * CW + 2;
    localparam int MW = 2 * CW;

    logic                   en;
    logic                   s1_valid_reg;
    logic                   s2_valid_reg;
    logic signed [2*CW-1:0] bb_reg;
    logic signed [2*CW-1:0] ac_reg;
    logic signed [CW-1:0]   a1_reg;
    logic signed [CW-1:0]   b1_reg;
    logic signed [DW-1:0]   disc_next;
    logic signed [DW-1:0]   disc_reg;
    logic signed [CW-1:0]   a2_reg;
    logic signed [CW-1:0]   b2_reg;
    qrr_pkg::root_flags_t   flags_next;
    qrr_pkg::root_flags_t   flags_reg;

    assign en         = !(s2_valid_reg && queue_full);
    assign coef.ready = en;

    assign disc_next = $signed({{2{bb_reg[2*CW-1]}}, bb_reg}) - $signed({ac_reg, 2'b00});

    always_comb
    begin
        if (disc_next < 0)
            flags_next.count = qrr_pkg::CNT_NONE;
        else if (disc_next == 0)
            flags_next.count = qrr_pkg::CNT_ONE;
        else
            flags_next.count = qrr_pkg::CNT_TWO;
        flags_next.lead = (a1_reg == 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= coef.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg    <= MW'(coef.coef_linear) * MW'(coef.coef_linear);
            ac_reg    <= MW'(coef.coef_square) * MW'(coef.coef_const);
            a1_reg    <= coef.coef_square;
            b1_reg    <= coef.coef_linear;
            disc_reg  <= disc_next;
            flags_reg <= flags_next;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
        end
    end

    assign push       = s2_valid_reg && !queue_full;
    assign push_a     = a2_reg;
    assign push_b     = b2_reg;
    assign push_disc  = disc_reg;
    assign push_flags = flags_reg;
endmodule

FILE: hdl/qrr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module qrr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qrr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_pop;

    assign full      = (count_reg == CNTW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
endmodule

FILE: hdl/qrr_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qrr_sqrt #(
    parameter int ROOT_W = 8,
    parameter int META_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_rad,
    input  logic [META_W-1:0]     in_meta,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic                  out_exact,
    output logic [META_W-1:0]     out_meta
);
    localparam int SW   = ROOT_W;
    localparam int RW   = 2 * SW;
    localparam int REMW = SW + 3;

    logic              s_valid [SW+1];
    logic [RW-1:0]     s_rad   [SW+1];
    logic [SW-1:0]     s_q     [SW+1];
    logic [REMW-1:0]   s_rem   [SW+1];
    logic [META_W-1:0] s_meta  [SW+1];

    assign s_valid[0] = in_valid;
    assign s_rad[0]   = in_rad;
    assign s_q[0]     = '0;
    assign s_rem[0]   = '0;
    assign s_meta[0]  = in_meta;

    for (genvar k = 0; k < SW; k++)
    begin : g_stage
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic            ge;

        assign rem_sh = {s_rem[k][REMW-3:0], s_rad[k][RW-1 -: 2]};
        assign trial  = {1'b0, s_q[k], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_valid[k+1] <= 1'b0;
            else if (en)
                s_valid[k+1] <= s_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
                s_q[k+1]    <= {s_q[k][SW-2:0], ge};
                s_rad[k+1]  <= {s_rad[k][RW-3:0], 2'b00};
                s_meta[k+1] <= s_meta[k];
            end
        end
    end

    assign out_valid = s_valid[SW];
    assign out_root  = s_q[SW];
    assign out_exact = (s_rem[SW] == '0);
    assign out_meta  = s_meta[SW];
endmodule

FILE: hdl/qrr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrr_div
// Pipelined restoring divider, two numerators over one divisor, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module qrr_div #(
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int META_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num_p,
    input  logic [NUM_W-1:0]  in_num_m,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [META_W-1:0] in_meta,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo_p,
    output logic [NUM_W-1:0]  out_quo_m,
    output logic [META_W-1:0] out_meta
);
    localparam int REMW = DEN_W + 1;

    logic              s_valid [NUM_W+1];
    logic [NUM_W-1:0]  s_num_p [NUM_W+1];
    logic [NUM_W-1:0]  s_num_m [NUM_W+1];
    logic [NUM_W-1:0]  s_quo_p [NUM_W+1];
    logic [NUM_W-1:0]  s_quo_m [NUM_W+1];
    logic [REMW-1:0]   s_rem_p [NUM_W+1];
    logic [REMW-1:0]   s_rem_m [NUM_W+1];
    logic [DEN_W-1:0]  s_den   [NUM_W+1];
    logic [META_W-1:0] s_meta  [NUM_W+1];

    assign s_valid[0] = in_valid;
    assign s_num_p[0] = in_num_p;
    assign s_num_m[0] = in_num_m;
    assign s_quo_p[0] = '0;
    assign s_quo_m[0] = '0;
    assign s_rem_p[0] = '0;
    assign s_rem_m[0] = '0;
    assign s_den[0]   = in_den;
    assign s_meta[0]  = in_meta;

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [REMW-1:0] sh_p;
        logic [REMW-1:0] sh_m;
        logic [REMW-1:0] den_ext;
        logic            ge_p;
        logic            ge_m;

        assign den_ext = {1'b0, s_den[k]};
        assign sh_p    = {s_rem_p[k][REMW-2:0], s_num_p[k][NUM_W-1]};
        assign sh_m    = {s_rem_m[k][REMW-2:0], s_num_m[k][NUM_W-1]};
        assign ge_p    = (sh_p >= den_ext);
        assign ge_m    = (sh_m >= den_ext);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_valid[k+1] <= 1'b0;
            else if (en)
                s_valid[k+1] <= s_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_rem_p[k+1] <= ge_p ? sh_p - den_ext : sh_p;
                s_rem_m[k+1] <= ge_m ? sh_m - den_ext : sh_m;
                s_quo_p[k+1] <= {s_quo_p[k][NUM_W-2:0], ge_p};
                s_quo_m[k+1] <= {s_quo_m[k][NUM_W-2:0], ge_m};
                s_num_p[k+1] <= {s_num_p[k][NUM_W-2:0], 1'b0};
                s_num_m[k+1] <= {s_num_m[k][NUM_W-2:0], 1'b0};
                s_den[k+1]   <= s_den[k];
                s_meta[k+1]  <= s_meta[k];
            end
        end
    end

    assign out_valid = s_valid[NUM_W];
    assign out_quo_p = s_quo_p[NUM_W];
    assign out_quo_m = s_quo_m[NUM_W];
    assign out_meta  = s_meta[NUM_W];
endmodule

FILE: hdl/quadratic_real_roots_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_real_roots_core
// Real roots of a*x*x + b*x + c in fixed point with FRAC_BITS fraction bits.
//
//   Port    Dir  Handshake     Payload
//   coef    in   valid/ready   coef_square, coef_linear, coef_const
//   roots   out  valid/ready   root_count, disc_value, root_plus, root_minus,
//                              lead_zero
//
// One triple per cycle sustained while roots.ready stays high. The square-root
// pipeline resolves SW root bits and the divider pipeline MAGW quotient bits
// (33 and 35 at default parameters).
// Reset clears all valid bits and the queue; no clearing pass.
// A stall on roots freezes the back pipeline; the front keeps filling the
// queue until it is full and then drops coef.ready.
// ----------------------------------------------------------------------------
module quadratic_real_roots_core #(
    parameter int COEF_WIDTH = qrr_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrr_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    qrr_coef_if.sink   coef,
    qrr_root_if.source roots
);
    localparam int CW    = COEF_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int DW    = 2 * CW + 2;
    localparam int SW    = (DW + 2 * F) / 2;
    localparam int XW    = CW + F + 2;
    localparam int NNW   = ((XW > SW + 1) ? XW : SW + 1) + 2;
    localparam int MAGW  = NNW - 1;
    localparam int DENW  = CW + 1;
    localparam int FW    = qrr_pkg::FLAGS_W;
    localparam int QW    = 2 * CW + DW + FW;
    localparam int DMW   = DW + FW + 2;
    localparam int DOW   = qrr_pkg::DISC_OUT_W;
    localparam int ROW   = qrr_pkg::ROOT_OUT_W;
    localparam int SATW  = NNW + ROW;
    localparam logic signed [SATW-1:0] RMAX = {{(SATW - ROW + 1){1'b0}}, {(ROW - 1){1'b1}}};
    localparam logic signed [SATW-1:0] RMIN = ~RMAX;

    // front and queue
    logic                   push;
    logic signed [CW-1:0]   push_a;
    logic signed [CW-1:0]   push_b;
    logic signed [DW-1:0]   push_disc;
    qrr_pkg::root_flags_t   push_flags;
    logic                   q_full;
    logic                   q_not_empty;
    logic [QW-1:0]          q_head;
    logic                   en;

    qrr_front #(.COEF_WIDTH(CW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef),
        .queue_full (q_full),
        .push       (push),
        .push_a     (push_a),
        .push_b     (push_b),
        .push_disc  (push_disc),
        .push_flags (push_flags)
    );

    qrr_queue #(.WIDTH(QW), .DEPTH(qrr_pkg::QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_a, push_b, push_disc, push_flags}),
        .full      (q_full),
        .pop       (en),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back: square root
    logic signed [DW-1:0]   h_disc;
    logic [2*SW-1:0]        rad;
    logic                   sq_valid;
    logic [SW-1:0]          sq_root;
    logic                   sq_exact;
    logic [QW-1:0]          sq_meta;

    assign h_disc = q_head[DW+FW-1:FW];
    assign rad    = {{(2 * SW - (DW - 1) - 2 * F){1'b0}}, h_disc[DW-2:0], {(2 * F){1'b0}}};

    qrr_sqrt #(.ROOT_W(SW), .META_W(QW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_not_empty),
        .in_rad    (rad),
        .in_meta   (q_head),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_exact (sq_exact),
        .out_meta  (sq_meta)
    );

    // back: numerators for the floor divisions
    logic signed [CW-1:0]   s_a;
    logic signed [CW-1:0]   s_b;
    logic signed [NNW-1:0]  x_val;
    logic signed [NNW-1:0]  tf;
    logic signed [NNW-1:0]  tc;
    logic signed [NNW-1:0]  n_p;
    logic signed [NNW-1:0]  n_m;
    logic [CW-1:0]          a_mag;
    logic                   pr_valid_reg;
    logic [MAGW-1:0]        pr_num_p_reg;
    logic [MAGW-1:0]        pr_num_m_reg;
    logic [DENW-1:0]        pr_den_reg;
    logic [DMW-1:0]         pr_meta_reg;

    assign s_a   = sq_meta[QW-1 -: CW];
    assign s_b   = sq_meta[QW-CW-1 -: CW];
    assign x_val = NNW'(s_a) - (NNW'(s_b) <<< F);
    assign tf    = $signed({{(NNW - SW){1'b0}}, sq_root});
    assign tc    = tf + $signed({{(NNW - 1){1'b0}}, !sq_exact});
    assign n_p   = s_a[CW-1] ? -(x_val + tc) : x_val + tf;
    assign n_m   = s_a[CW-1] ? tf - x_val : x_val - tc;
    assign a_mag = s_a[CW-1] ? CW'(-s_a) : CW'(s_a);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_valid_reg <= 1'b0;
        else if (en)
            pr_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_num_p_reg <= n_p[NNW-1] ? ~n_p[MAGW-1:0] : n_p[MAGW-1:0];
            pr_num_m_reg <= n_m[NNW-1] ? ~n_m[MAGW-1:0] : n_m[MAGW-1:0];
            pr_den_reg   <= {a_mag, 1'b0};
            pr_meta_reg  <= {sq_meta[DW+FW-1:0], n_p[NNW-1], n_m[NNW-1]};
        end
    end

    // back: divider
    logic                   dv_valid;
    logic [MAGW-1:0]        dv_quo_p;
    logic [MAGW-1:0]        dv_quo_m;
    logic [DMW-1:0]         dv_meta;

    qrr_div #(.NUM_W(MAGW), .DEN_W(DENW), .META_W(DMW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pr_valid_reg),
        .in_num_p  (pr_num_p_reg),
        .in_num_m  (pr_num_m_reg),
        .in_den    (pr_den_reg),
        .in_meta   (pr_meta_reg),
        .out_valid (dv_valid),
        .out_quo_p (dv_quo_p),
        .out_quo_m (dv_quo_m),
        .out_meta  (dv_meta)
    );

    // back: sign fixup, saturation, output register
    qrr_pkg::root_flags_t   d_flags;
    logic signed [DW-1:0]   d_disc;
    logic signed [SATW-1:0] v_p;
    logic signed [SATW-1:0] v_m;
    logic signed [ROW-1:0]  r_p;
    logic signed [ROW-1:0]  r_m;
    logic                   zero_roots;
    logic [DW+DOW-1:0]      disc_wide;
    logic                   out_valid_reg;
    logic [1:0]             count_reg;
    logic signed [DOW-1:0]  disc_reg;
    logic signed [ROW-1:0]  plus_reg;
    logic signed [ROW-1:0]  minus_reg;
    logic                   lead_reg;

    assign d_disc     = dv_meta[DMW-1 -: DW];
    assign d_flags    = dv_meta[FW+1:2];
    assign v_p        = SATW'($signed(dv_meta[1] ? ~{1'b0, dv_quo_p} : {1'b0, dv_quo_p}));
    assign v_m        = SATW'($signed(dv_meta[0] ? ~{1'b0, dv_quo_m} : {1'b0, dv_quo_m}));
    assign r_p        = (v_p > RMAX) ? RMAX[ROW-1:0] : (v_p < RMIN) ? RMIN[ROW-1:0] : v_p[ROW-1:0];
    assign r_m        = (v_m > RMAX) ? RMAX[ROW-1:0] : (v_m < RMIN) ? RMIN[ROW-1:0] : v_m[ROW-1:0];
    assign zero_roots = (d_flags.count == qrr_pkg::CNT_NONE) || d_flags.lead;
    assign disc_wide  = {{DOW{d_disc[DW-1]}}, d_disc};

    assign en = !out_valid_reg || roots.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            count_reg <= d_flags.count;
            disc_reg  <= disc_wide[DOW-1:0];
            plus_reg  <= zero_roots ? '0 : r_p;
            minus_reg <= zero_roots ? '0 : r_m;
            lead_reg  <= d_flags.lead;
        end
    end

    assign roots.valid      = out_valid_reg;
    assign roots.root_count = count_reg;
    assign roots.disc_value = disc_reg;
    assign roots.root_plus  = plus_reg;
    assign roots.root_minus = minus_reg;
    assign roots.lead_zero  = lead_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        roots.valid && (roots.root_count == qrr_pkg::CNT_NONE || roots.lead_zero)
        |-> roots.root_plus == '0 && roots.root_minus == '0)
        else $error("roots not zero without real roots");

    assert property (@(posedge clk) disable iff (!rst_n)
        roots.valid && roots.root_count == qrr_pkg::CNT_ONE && !roots.lead_zero
        |-> roots.root_plus == roots.root_minus)
        else $error("double root gives two values");

    assert property (@(posedge clk) disable iff (!rst_n)
        roots.valid |-> ((roots.root_count == qrr_pkg::CNT_NONE) == (roots.disc_value < 0)))
        else $error("root count disagrees with discriminant sign");
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quadratic_real_roots_core. A directed table covers
// the coefficient extremes, a zero square term, no, double and distinct
// roots and rounding ties. Random triples follow, many built from integer or
// half-integer roots. Every result is checked against a typed expectation or
// a bit-exact predictor while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    localparam int  CW        = qrr_pkg::COEF_WIDTH_DEF;
    localparam int  FB        = qrr_pkg::FRAC_BITS_DEF;
    localparam int  DOW       = qrr_pkg::DISC_OUT_W;
    localparam int  ROW       = qrr_pkg::ROOT_OUT_W;
    localparam int  N_RANDOM  = 1400;
    localparam int  MAX_CYCLES = 400000;
    localparam int  DRAIN     = 120;
    localparam longint ROOT_HI = (longint'(1) << (ROW - 1)) - 1;
    localparam longint ROOT_LO = -ROOT_HI - 1;

    typedef struct packed {
        qrr_pkg::root_count_t count;
        logic [DOW-1:0]       disc;
        logic [ROW-1:0]       rp;
        logic [ROW-1:0]       rm;
        logic                 lead;
    } roots_t;

    typedef struct {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        bit                   typed;
        roots_t               want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qrr_coef_if #(.COEF_WIDTH(CW)) coef ();
    qrr_root_if roots ();

    quadratic_real_roots_core #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .coef  (coef.sink),
        .roots (roots.source)
    );

    always #6 clk = ~clk;

    roots_t pending_roots[$];
    int     n_errors = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    int     n_two = 0;
    int     n_lead = 0;
    longint cycle = 0;
    bit     quiet = 1'b0;

    function automatic longint floor_div(longint n, longint m);
        longint q;
        q = n / m;
        if ((n % m) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic logic [ROW-1:0] clip_root(longint r);
        if (r > ROOT_HI)
            r = ROOT_HI;
        if (r < ROOT_LO)
            r = ROOT_LO;
        return r[ROW-1:0];
    endfunction

    function automatic roots_t solve_roots(logic signed [CW-1:0] a_in,
                                           logic signed [CW-1:0] b_in,
                                           logic signed [CW-1:0] c_in);
        roots_t       res;
        longint       a, b, c, d, x, den, tf, tc, p, m;
        logic [127:0] n, sq, cand;
        logic [63:0]  r;
        a = a_in;
        b = b_in;
        c = c_in;
        d = b * b - 4 * a * c;
        res.count = (d < 0) ? qrr_pkg::CNT_NONE :
                    ((d > 0) ? qrr_pkg::CNT_TWO : qrr_pkg::CNT_ONE);
        res.disc  = d[DOW-1:0];
        res.rp    = '0;
        res.rm    = '0;
        res.lead  = (a == 0);
        if (d >= 0 && a != 0)
        begin
            n = {64'b0, d} << (2 * FB);
            r = '0;
            for (int i = 63; i >= 0; i--)
            begin
                cand = {64'b0, r | (64'd1 << i)};
                sq = cand * cand;
                if (sq <= n)
                    r = cand[63:0];
            end
            sq = {64'b0, r} * {64'b0, r};
            tf = r;
            tc = (sq == n) ? tf : tf + 1;
            x = -b * (longint'(1) << FB) + a;
            den = 2 * a;
            if (den > 0)
            begin
                p = floor_div(x + tf, den);
                m = floor_div(x - tc, den);
            end
            else
            begin
                p = floor_div(-(x + tc), -den);
                m = floor_div(-(x - tf), -den);
            end
            res.rp = clip_root(p);
            res.rm = clip_root(m);
        end
        return res;
    endfunction

    function automatic roots_t mk(qrr_pkg::root_count_t cnt, longint d, longint p, longint m,
                                  logic lead);
        roots_t res;
        res.count = cnt;
        res.disc  = d[DOW-1:0];
        res.rp    = p[ROW-1:0];
        res.rm    = m[ROW-1:0];
        res.lead  = lead;
        return res;
    endfunction

    task automatic send_triple(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                               logic signed [CW-1:0] c, roots_t want);
        while (!quiet && $urandom_range(99) < 34)
        begin
            coef.valid <= 1'b0;
            @(posedge clk);
        end
        coef.valid       <= 1'b1;
        coef.coef_square <= a;
        coef.coef_linear <= b;
        coef.coef_const  <= c;
        do
            @(posedge clk);
        while (!coef.ready);
        pending_roots.push_back(want);
        n_sent++;
    endtask

    // receiver: random stalls, one long hold-off, and a calm stretch
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roots.ready <= 1'b0;
        end
        else
        begin
            if (!hold_done && n_sent >= 300)
            begin
                hold_done <= 1'b1;
                hold_left <= 600;
                roots.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                roots.ready <= 1'b0;
            end
            else
            begin
                roots.ready <= quiet || ($urandom_range(99) >= 34);
            end
        end
    end

    always @(posedge clk)
    begin
        roots_t want;
        if (rst_n && roots.valid && roots.ready)
        begin
            if (pending_roots.size() == 0)
            begin
                $display("%0t: unexpected result transfer count=%0d", $time, roots.root_count);
                n_errors++;
            end
            else
            begin
                want = pending_roots.pop_front();
                n_checked++;
                if (want.count == qrr_pkg::CNT_TWO)
                    n_two++;
                if (want.lead)
                    n_lead++;
                if (roots.root_count !== want.count)
                begin
                    $display("%0t: root_count expected %0d actual %0d", $time, want.count,
                             roots.root_count);
                    n_errors++;
                end
                if (roots.disc_value !== want.disc)
                begin
                    $display("%0t: disc_value expected %0d actual %0d", $time,
                             $signed(want.disc), roots.disc_value);
                    n_errors++;
                end
                if (roots.root_plus !== want.rp)
                begin
                    $display("%0t: root_plus expected %0d actual %0d", $time,
                             $signed(want.rp), roots.root_plus);
                    n_errors++;
                end
                if (roots.root_minus !== want.rm)
                begin
                    $display("%0t: root_minus expected %0d actual %0d", $time,
                             $signed(want.rm), roots.root_minus);
                    n_errors++;
                end
                if (roots.lead_zero !== want.lead)
                begin
                    $display("%0t: lead_zero expected %0d actual %0d", $time, want.lead,
                             roots.lead_zero);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= MAX_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_roots.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] clip_coef(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[CW-1:0];
    endfunction

    initial
    begin
        row_t  table_rows[$];
        row_t  rw;
        longint a, r1, r2;
        logic signed [CW-1:0] ca, cb, cc;
        int    kind;

        coef.valid       = 1'b0;
        coef.coef_square = '0;
        coef.coef_linear = '0;
        coef.coef_const  = '0;

        table_rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1,
                               mk(qrr_pkg::CNT_ONE, 0, 0, 0, 1'b1)});
        table_rows.push_back('{16'sd0, 16'sd5, 16'sd3, 1,
                               mk(qrr_pkg::CNT_TWO, 25, 0, 0, 1'b1)});
        table_rows.push_back('{16'sd0, 16'sh8000, 16'sd7, 1,
                               mk(qrr_pkg::CNT_TWO, 1073741824, 0, 0, 1'b1)});
        table_rows.push_back('{16'sd1, 16'sd0, 16'sd1, 1,
                               mk(qrr_pkg::CNT_NONE, -4, 0, 0, 1'b0)});
        table_rows.push_back('{16'sd1, 16'sd0, -16'sd1, 1,
                               mk(qrr_pkg::CNT_TWO, 4, 65536, -65536, 1'b0)});
        table_rows.push_back('{16'sd1, -16'sd2, 16'sd1, 1,
                               mk(qrr_pkg::CNT_ONE, 0, 65536, 65536, 1'b0)});
        table_rows.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 0, '0});
        table_rows.push_back('{16'sh8000, 16'sh8000, 16'sd32767, 0, '0});
        table_rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 0, '0});
        table_rows.push_back('{16'sd32767, 16'sh8000, 16'sh8000, 0, '0});
        table_rows.push_back('{16'sd1, 16'sh8000, 16'sh8000, 0, '0});
        table_rows.push_back('{16'sd1, 16'sd32767, 16'sd0, 0, '0});
        table_rows.push_back('{-16'sd1, 16'sd1, 16'sd0, 0, '0});
        table_rows.push_back('{16'sd4, 16'sd4, 16'sd1, 0, '0});
        table_rows.push_back('{16'sd2, 16'sd1, 16'sd0, 0, '0});
        table_rows.push_back('{-16'sd2, 16'sd3, 16'sd0, 0, '0});
        table_rows.push_back('{16'sd3, 16'sd5, -16'sd7, 0, '0});
        table_rows.push_back('{16'sd32767, 16'sd1, 16'sh8000, 0, '0});
        table_rows.push_back('{-16'sd1, 16'sd0, -16'sd1, 0, '0});
        table_rows.push_back('{16'sh8000, 16'sd1, 16'sd0, 0, '0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
        begin
            rw = table_rows[i];
            send_triple(rw.a, rw.b, rw.c,
                        rw.typed ? rw.want : solve_roots(rw.a, rw.b, rw.c));
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            quiet = (i >= 700 && i < 950);
            kind = $urandom_range(99);
            if (kind < 35)
            begin
                ca = CW'($urandom);
                cb = CW'($urandom);
                cc = CW'($urandom);
            end
            else if (kind < 80)
            begin
                // integer or half-integer roots
                a = longint'($urandom_range(60)) - 30;
                if (a == 0)
                    a = 2;
                r1 = longint'($urandom_range(200)) - 100;
                r2 = ($urandom_range(3) == 0) ? r1 : longint'($urandom_range(200)) - 100;
                if ($urandom_range(1))
                begin
                    ca = clip_coef(4 * a);
                    cb = clip_coef(-2 * a * (r1 + r2));
                    cc = clip_coef(a * r1 * r2);
                end
                else
                begin
                    ca = clip_coef(a);
                    cb = clip_coef(-a * (r1 + r2));
                    cc = clip_coef(a * r1 * r2);
                end
            end
            else if (kind < 90)
            begin
                ca = clip_coef(longint'($urandom_range(16)) - 8);
                cb = clip_coef(longint'($urandom_range(16)) - 8);
                cc = clip_coef(longint'($urandom_range(16)) - 8);
            end
            else if (kind < 95)
            begin
                ca = '0;
                cb = CW'($urandom);
                cc = CW'($urandom);
            end
            else
            begin
                ca = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                cb = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                cc = CW'($urandom);
            end
            send_triple(ca, cb, cc, solve_roots(ca, cb, cc));
        end
        coef.valid <= 1'b0;

        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Checked %0d of %0d triples: %0d with two roots, %0d with zero square term.",
                 n_checked, n_sent, n_two, n_lead);
        if (n_errors == 0 && pending_roots.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", n_errors, pending_roots.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: sim.f
hdl/qrr_pkg.sv
hdl/qrr_coef_if.sv
hdl/qrr_root_if.sv
hdl/qrr_front.sv
hdl/qrr_queue.sv
hdl/qrr_sqrt.sv
hdl/qrr_div.sv
hdl/quadratic_real_roots_core.sv
bench/tb.sv
